// ===== hw/rtl/assert_macros.svh =====
// assertion helpers included by the scanner core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define ASSERT_PROP(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("property failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(name, clk, rstn, cond) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rstn, prop)

`define ASSERT_NEVER(name, clk, rstn, cond)

`endif

`endif

// ===== hw/rtl/mbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

	localparam int ADDR_W  = 64;
	localparam int COUNT_W = 32;
	localparam int LEN_W   = 5;
	localparam int CARE_W  = 16;
	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	localparam logic [COUNT_W-1:0] MATCH_LIMIT = COUNT_W'(10);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

	typedef enum logic [1:0] {
		OUT_NONE    = 2'd0,
		OUT_MANY    = 2'd1,
		OUT_UNIQUE  = 2'd2,
		OUT_NEAREST = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_CARE_MASK      = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_SECTION_BASE   = 3'd4,
		REG_PRIOR_ADDR     = 3'd5,
		REG_BASE_SHIFT     = 3'd6,
		REG_UNUSED         = 3'd7
	} reg_index_t;

	// compare result of one byte leaving the matcher
	typedef struct packed {
		logic valid;
		logic hit;
		logic last;
	} match_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbps_scan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mbps_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       end_of_section;

	modport source (output valid, code_byte, end_of_section, input ready);
	modport sink (input valid, code_byte, end_of_section, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbps_report_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mbps_report_if
	import mbps_pkg::*;
	;
	logic                valid;
	logic                ready;
	outcome_t            outcome;
	logic [COUNT_W-1:0]  match_total;
	logic [ADDR_W-1:0]   rebased_addr;
	logic signed [ADDR_W-1:0] address_delta;

	modport source (output valid, outcome, match_total, rebased_addr, address_delta,
		input ready);
	modport sink (input valid, outcome, match_total, rebased_addr, address_delta,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/masked_byte_pattern_scanner_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// masked byte pattern scanner
// scan: one code byte per beat, end_of_section set on the last byte of a section.
// report: one beat per section, sent after its last byte, carrying the outcome,
//   the saturating match count, the rebased address and the delta to the prior address.
// apb port: 64-bit registers at byte address 8*index; the user must write them only
//   while idle, which the block does not enforce.
// throughput: one byte per cycle while scan.ready is high.
// steps to the report: window compare, address add, distance, best-match update, rebase.
// reset clears the registers to their defaults and the scan state to zero;
//   scan.ready is high once reset is released.
// a report that is not taken holds on the port; bytes keep flowing until a
//   second finished report is waiting behind it, then scan.ready drops until
//   the first report is taken.
`include "assert_macros.svh"

module masked_byte_pattern_scanner_core
	import mbps_pkg::*;
#(
	parameter int PATTERN_MAX   = 16,
	parameter int POSITION_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	mbps_scan_if.sink                scan,
	mbps_report_if.source            report,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0]  pwdata,
	output logic      [PDATA_W-1:0]  prdata,
	output logic                     pready
);

	logic [63:0]        pattern_low_q;
	logic [63:0]        pattern_high_q;
	logic [CARE_W-1:0]  care_mask_q;
	logic [LEN_W-1:0]   pattern_length_q;
	logic [ADDR_W-1:0]  section_base_q;
	logic [ADDR_W-1:0]  prior_addr_q;
	logic [ADDR_W-1:0]  base_shift_q;
	logic [ADDR_W-1:0]  target_q;

	reg_index_t         reg_idx;
	logic               cfg_write;

	logic               advance;
	logic               accept;
	match_t             match_s1;
	logic [POSITION_BITS-1:0] offset_s1;

	match_t             match_s2;
	logic [ADDR_W-1:0]  addr_s2;
	match_t             match_s3;
	logic [ADDR_W-1:0]  addr_s3;
	logic [ADDR_W-1:0]  dist_s3;
	logic [ADDR_W-1:0]  diff_fwd;
	logic [ADDR_W-1:0]  diff_rev;

	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  best_addr_q;
	logic [ADDR_W-1:0]  best_dist_q;
	logic               take;
	logic [COUNT_W-1:0] count_next;

	logic               fin_valid_s4;
	logic [COUNT_W-1:0] count_s4;
	logic [ADDR_W-1:0]  best_s4;

	logic               out_valid_q;
	logic               out_load;
	outcome_t           outcome_d;

	// apb register file
	assign reg_idx   = reg_index_t'(paddr[PADDR_W-1:3]);
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_comb begin
		unique case (reg_idx)
			REG_PATTERN_LOW:    prdata = pattern_low_q;
			REG_PATTERN_HIGH:   prdata = pattern_high_q;
			REG_CARE_MASK:      prdata = PDATA_W'(care_mask_q);
			REG_PATTERN_LENGTH: prdata = PDATA_W'(pattern_length_q);
			REG_SECTION_BASE:   prdata = section_base_q;
			REG_PRIOR_ADDR:     prdata = prior_addr_q;
			REG_BASE_SHIFT:     prdata = base_shift_q;
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= '1;
			pattern_length_q <= LEN_W'(1);
			section_base_q   <= '0;
			prior_addr_q     <= '0;
			base_shift_q     <= '0;
			target_q         <= '0;
		end else begin
			// old address moved into runtime space
			target_q <= prior_addr_q + base_shift_q;
			if (cfg_write) begin
				unique case (reg_idx)
					REG_PATTERN_LOW:    pattern_low_q    <= pwdata;
					REG_PATTERN_HIGH:   pattern_high_q   <= pwdata;
					REG_CARE_MASK:      care_mask_q      <= pwdata[CARE_W-1:0];
					REG_PATTERN_LENGTH: pattern_length_q <= pwdata[LEN_W-1:0];
					REG_SECTION_BASE:   section_base_q   <= pwdata;
					REG_PRIOR_ADDR:     prior_addr_q     <= pwdata;
					REG_BASE_SHIFT:     base_shift_q     <= pwdata;
					default:            ;
				endcase
			end
		end
	end

	// the whole pipe stalls only when a finished report waits behind a held one
	assign advance    = !(fin_valid_s4 && out_valid_q && !report.ready);
	assign scan.ready = advance;
	assign accept     = scan.valid && advance;

	mbps_matcher #(
		.PATTERN_MAX   (PATTERN_MAX),
		.POSITION_BITS (POSITION_BITS)
	) u_matcher (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.accept         (accept),
		.code_byte      (scan.code_byte),
		.end_of_section (scan.end_of_section),
		.pattern_low    (pattern_low_q),
		.pattern_high   (pattern_high_q),
		.care_mask      (care_mask_q),
		.pattern_length (pattern_length_q),
		.match_s1       (match_s1),
		.offset_s1      (offset_s1)
	);

	assign diff_fwd = addr_s2 - target_q;
	assign diff_rev = target_q - addr_s2;

	always_comb begin
		take = match_s3.hit && ((count_q == '0) || (dist_s3 < best_dist_q));
		count_next = (match_s3.hit && (count_q != COUNT_MAX)) ?
			count_q + COUNT_W'(1) : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s2     <= '0;
			match_s3     <= '0;
			count_q      <= '0;
			best_addr_q  <= '0;
			best_dist_q  <= '0;
			fin_valid_s4 <= 1'b0;
		end else if (advance) begin
			match_s2     <= match_s1;
			match_s3     <= match_s2;
			fin_valid_s4 <= match_s3.valid && match_s3.last;
			if (match_s3.valid) begin
				if (match_s3.last) begin
					count_q     <= '0;
					best_addr_q <= '0;
					best_dist_q <= '0;
				end else begin
					count_q <= count_next;
					if (take) begin
						best_addr_q <= addr_s3;
						best_dist_q <= dist_s3;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s2  <= section_base_q + ADDR_W'(offset_s1);
			addr_s3  <= addr_s2;
			dist_s3  <= diff_fwd[ADDR_W-1] ? diff_rev : diff_fwd;
			count_s4 <= count_next;
			best_s4  <= take ? addr_s3 : best_addr_q;
		end
	end

	// report stage
	assign out_load = !out_valid_q || report.ready;

	always_comb begin
		priority if (count_s4 == '0) begin
			outcome_d = OUT_NONE;
		end else if (count_s4 > MATCH_LIMIT) begin
			outcome_d = OUT_MANY;
		end else if (count_s4 == COUNT_W'(1)) begin
			outcome_d = OUT_UNIQUE;
		end else begin
			outcome_d = OUT_NEAREST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= fin_valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			report.outcome     <= outcome_d;
			report.match_total <= count_s4;
			if (outcome_d == OUT_UNIQUE || outcome_d == OUT_NEAREST) begin
				report.rebased_addr  <= best_s4 - base_shift_q;
				// best - shift - old, with old + shift already summed
				report.address_delta <= best_s4 - target_q;
			end else begin
				report.rebased_addr  <= '0;
				report.address_delta <= '0;
			end
		end
	end

	assign report.valid = out_valid_q;

	`ASSERT_PROP(a_empty_report_zero, clk, arst_n,
		out_valid_q && (report.outcome == OUT_NONE || report.outcome == OUT_MANY) |->
		report.rebased_addr == '0 && report.address_delta == '0)
	`ASSERT_PROP(a_unique_is_one, clk, arst_n,
		out_valid_q && report.outcome == OUT_UNIQUE |-> report.match_total == COUNT_W'(1))
	`ASSERT_PROP(a_section_end_clears, clk, arst_n,
		advance && match_s3.valid && match_s3.last |=> count_q == '0)
	`ASSERT_PROP(a_held_report_kept, clk, arst_n,
		fin_valid_s4 && !advance |=> fin_valid_s4 && out_valid_q)
	`ASSERT_NEVER(a_stall_without_backlog, clk, arst_n,
		!scan.ready && !(out_valid_q && fin_valid_s4))

endmodule

`default_nettype wire

// ===== hw/rtl/mbps_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbps_matcher
	import mbps_pkg::*;
#(
	parameter int PATTERN_MAX   = 16,
	parameter int POSITION_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     advance,
	input  wire logic                     accept,
	input  wire logic [7:0]               code_byte,
	input  wire logic                     end_of_section,
	input  wire logic [63:0]              pattern_low,
	input  wire logic [63:0]              pattern_high,
	input  wire logic [CARE_W-1:0]        care_mask,
	input  wire logic [LEN_W-1:0]         pattern_length,
	output match_t                        match_s1,
	output logic [POSITION_BITS-1:0]      offset_s1
);

	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [7:0]               window_q [PATTERN_MAX];
	logic [7:0]               win_next [PATTERN_MAX];
	logic [POSITION_BITS-1:0] pos_q;
	logic [LEN_W-1:0]         len_eff;
	logic [LEN_W-1:0]         len_m1;
	logic [PATTERN_MAX-1:0]   byte_ok;
	logic                     pos_ok;
	logic                     hit;

	function automatic logic [7:0] pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
		input int unsigned j);
		logic [63:0] word;
		word = (j < 8) ? lo : hi;
		return word[8*(j%8) +: 8];
	endfunction

	always_comb begin
		len_eff = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pattern_length;
		len_m1  = len_eff - LEN_W'(1);
		win_next[0] = code_byte;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_next[k] = window_q[k-1];
		end
		// pattern byte j lines up with the byte that arrived len-1-j beats ago
		for (int j = 0; j < PATTERN_MAX; j++) begin
			byte_ok[j] = (LEN_W'(j) >= len_eff) || !care_mask[j] ||
				(win_next[IDX_W'(len_m1 - LEN_W'(j))] ==
				pattern_byte(pattern_low, pattern_high, j));
		end
		pos_ok = (len_eff != '0) && (pos_q >= POSITION_BITS'(len_m1));
		hit    = pos_ok && (&byte_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int k = 0; k < PATTERN_MAX; k++) begin
				window_q[k] <= '0;
			end
			match_s1 <= '0;
		end else begin
			if (accept) begin
				if (end_of_section) begin
					pos_q <= '0;
					for (int k = 0; k < PATTERN_MAX; k++) begin
						window_q[k] <= '0;
					end
				end else begin
					pos_q <= (pos_q == POS_MAX) ? pos_q : pos_q + POSITION_BITS'(1);
					for (int k = 0; k < PATTERN_MAX; k++) begin
						window_q[k] <= win_next[k];
					end
				end
			end
			if (advance) begin
				match_s1.valid <= accept;
				match_s1.hit   <= accept && hit;
				match_s1.last  <= accept && end_of_section;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			offset_s1 <= pos_q - POSITION_BITS'(len_m1);
		end
	end

endmodule

`default_nettype wire

// ===== tb/section_predictor_pkg.sv =====
`timescale 1ns / 1ps

package section_predictor_pkg;
	import mbps_pkg::*;

	typedef struct {
		outcome_t           outcome;
		logic [COUNT_W-1:0] match_total;
		logic [ADDR_W-1:0]  rebased_addr;
		logic [ADDR_W-1:0]  address_delta;
	} section_report_t;

	class section_predictor;
		logic [ADDR_W-1:0]  pattern_low;
		logic [ADDR_W-1:0]  pattern_high;
		logic [CARE_W-1:0]  care_mask;
		logic [LEN_W-1:0]   pattern_length;
		logic [ADDR_W-1:0]  section_base;
		logic [ADDR_W-1:0]  prior_address;
		logic [ADDR_W-1:0]  base_shift;

		logic [7:0]         window [16];
		logic [31:0]        position;
		logic [COUNT_W-1:0] hits;
		logic [ADDR_W-1:0]  best_address;
		logic [ADDR_W-1:0]  best_distance;

		section_report_t    expected_reports [$];
		int                 errors;
		int                 shown;

		function new();
			pattern_low    = '0;
			pattern_high   = '0;
			care_mask      = '1;
			pattern_length = LEN_W'(1);
			section_base   = '0;
			prior_address  = '0;
			base_shift     = '0;
			errors         = 0;
			shown          = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			foreach (window[k])
				window[k] = 8'h00;
			position      = '0;
			hits          = '0;
			best_address  = '0;
			best_distance = '0;
		endfunction

		function void write_reg(reg_index_t idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_PATTERN_LOW:    pattern_low    = value;
				REG_PATTERN_HIGH:   pattern_high   = value;
				REG_CARE_MASK:      care_mask      = value[CARE_W-1:0];
				REG_PATTERN_LENGTH: pattern_length = value[LEN_W-1:0];
				REG_SECTION_BASE:   section_base   = value;
				REG_PRIOR_ADDR:     prior_address  = value;
				REG_BASE_SHIFT:     base_shift     = value;
				default: ;
			endcase
		endfunction

		// one accepted code byte; queues a report on the last byte of a section
		function void note_byte(logic [7:0] code_byte, logic end_of_section);
			int                len;
			int                k;
			int                j;
			logic              hit;
			logic [127:0]      pattern;
			logic [ADDR_W-1:0] addr;
			logic [ADDR_W-1:0] diff;
			logic [ADDR_W-1:0] span;
			section_report_t   rep;
			len = (pattern_length > 16) ? 16 : int'(pattern_length);
			pattern = {pattern_high, pattern_low};
			for (k = 15; k > 0; k--)
				window[k] = window[k-1];
			window[0] = code_byte;
			if (len > 0 && position >= 32'(len - 1)) begin
				hit = 1'b1;
				for (j = 0; j < len; j++)
					if (care_mask[j] && window[len-1-j] != pattern[8*j +: 8])
						hit = 1'b0;
				if (hit) begin
					addr = section_base + ({32'b0, position} - 64'(len - 1));
					diff = addr - (prior_address + base_shift);
					// magnitude read as signed, so the most negative gives 2^63
					span = diff[63] ? -diff : diff;
					if (hits == 0 || span < best_distance) begin
						best_address  = addr;
						best_distance = span;
					end
					if (hits != COUNT_MAX)
						hits++;
				end
			end
			if (position != '1)
				position++;
			if (!end_of_section)
				return;
			rep.match_total   = hits;
			rep.rebased_addr  = '0;
			rep.address_delta = '0;
			if (hits == 0) begin
				rep.outcome = OUT_NONE;
			end else if (hits > MATCH_LIMIT) begin
				rep.outcome = OUT_MANY;
			end else begin
				rep.outcome       = (hits == 1) ? OUT_UNIQUE : OUT_NEAREST;
				rep.rebased_addr  = best_address - base_shift;
				rep.address_delta = rep.rebased_addr - prior_address;
			end
			expected_reports = {expected_reports, rep};
			clear_scan();
		endfunction

		function void flag(string field, logic [63:0] want, logic [63:0] got);
			errors++;
			if (shown < 10) begin
				shown++;
				$display("mismatch %s: expected %h, got %h", field, want, got);
			end
		endfunction

		function void check_report(outcome_t outcome, logic [COUNT_W-1:0] match_total,
				logic [ADDR_W-1:0] rebased_addr, logic [ADDR_W-1:0] address_delta);
			section_report_t want;
			if (expected_reports.size() == 0) begin
				flag("unexpected report, outcome", '0, 64'(outcome));
				return;
			end
			want = expected_reports.pop_front();
			if (outcome !== want.outcome)
				flag("outcome", 64'(want.outcome), 64'(outcome));
			if (match_total !== want.match_total)
				flag("match_total", 64'(want.match_total), 64'(match_total));
			if (rebased_addr !== want.rebased_addr)
				flag("rebased_addr", want.rebased_addr, rebased_addr);
			if (address_delta !== want.address_delta)
				flag("address_delta", want.address_delta, address_delta);
		endfunction
	endclass

endpackage

// ===== tb/tb_masked_byte_pattern_scanner_core.sv =====
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scanner_core;
	import mbps_pkg::*;
	import section_predictor_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	mbps_scan_if   scan_bus ();
	mbps_report_if report_bus ();

	section_predictor pred = new();

	logic [7:0] section_bytes [$];
	logic       feed_quiet;
	logic       drain_quiet;
	int         bytes_sent;

	masked_byte_pattern_scanner_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan    (scan_bus),
		.report  (report_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

	task automatic write_reg(reg_index_t idx, logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pred.write_reg(idx, value);
	endtask

	// registers change only once every report is out and the pipe has drained
	task automatic wait_idle();
		scan_bus.valid <= 1'b0;
		while (pred.expected_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// valid is left high after the last beat; the next section or wait_idle takes over
	task automatic send_section();
		int gap;
		foreach (section_bytes[i]) begin
			gap = feed_quiet ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				scan_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			scan_bus.valid          <= 1'b1;
			scan_bus.code_byte      <= section_bytes[i];
			scan_bus.end_of_section <= (i == section_bytes.size() - 1);
			do @(posedge clk); while (!scan_bus.ready);
			pred.note_byte(section_bytes[i], i == section_bytes.size() - 1);
			bytes_sent++;
		end
	endtask

	initial begin
		int stall;
		report_bus.ready <= 1'b0;
		drain_quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				drain_quiet = ($urandom_range(0, 2) == 0);
			stall = drain_quiet ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				report_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			report_bus.ready <= 1'b1;
			do @(posedge clk); while (!report_bus.valid);
			pred.check_report(report_bus.outcome, report_bus.match_total,
				report_bus.rebased_addr, report_bus.address_delta);
		end
	end

	initial begin
		logic [127:0]       pat;
		logic [CARE_W-1:0]  care;
		logic [ADDR_W-1:0]  base;
		logic [ADDR_W-1:0]  shift;
		logic [ADDR_W-1:0]  old;
		logic [PDATA_W-1:0] word;
		int                 len;
		int                 eff;
		int                 nbytes;
		int                 plants;
		int                 pos;
		int                 pick;
		logic               mixed;

		arst_n                  <= 1'b0;
		psel                    <= 1'b0;
		penable                 <= 1'b0;
		pwrite                  <= 1'b0;
		paddr                   <= '0;
		pwdata                  <= '0;
		scan_bus.valid          <= 1'b0;
		scan_bus.code_byte      <= 8'h00;
		scan_bus.end_of_section <= 1'b0;
		feed_quiet = 1'b0;
		bytes_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two hits at equal distance from the old address: the first is kept
		write_reg(REG_PRIOR_ADDR, 64'd1);
		section_bytes = '{8'h00, 8'hFF, 8'h00};
		send_section();
		section_bytes = '{8'hFF};
		send_section();

		// a length of zero never matches
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 64'd0);
		section_bytes = '{8'h00};
		send_section();

		// overlong length clamps to sixteen, so four bytes are too short
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 64'd20);
		write_reg(REG_PATTERN_LOW, '1);
		write_reg(REG_PATTERN_HIGH, '1);
		section_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_section();

		// old address half the space away: distance of 2^63 against 2^63-1
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 64'd1);
		write_reg(REG_PATTERN_LOW, '0);
		write_reg(REG_PRIOR_ADDR, 64'h8000_0000_0000_0000);
		section_bytes = '{8'h00, 8'h00};
		send_section();

		// eleven hits is too many
		section_bytes.delete();
		repeat (11) section_bytes = {section_bytes, 8'h00};
		send_section();
		wait_idle();

		while (bytes_sent < 1110) begin
			pat = {$urandom, $urandom, $urandom, $urandom};
			case ($urandom_range(0, 9))
				0:          care = '0;
				1, 2, 3, 4: care = '1;
				default:    care = CARE_W'($urandom | $urandom);
			endcase
			case ($urandom_range(0, 19))
				0:       len = 0;
				1:       len = 16;
				2:       len = $urandom_range(17, 31);
				3, 4:    len = $urandom_range(9, 15);
				default: len = $urandom_range(1, 6);
			endcase
			case ($urandom_range(0, 3))
				0:       base = '0;
				1:       base = -64'($urandom_range(1, 30));
				default: base = {$urandom, $urandom};
			endcase
			shift = $urandom_range(0, 1) ? '0 : {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0:       old = '0;
				1:       old = {$urandom, $urandom};
				default: old = base - shift + 64'($urandom_range(0, 40));
			endcase

			write_reg(REG_PATTERN_LOW, pat[63:0]);
			write_reg(REG_PATTERN_HIGH, pat[127:64]);
			word = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
			word[CARE_W-1:0] = care;
			write_reg(REG_CARE_MASK, word);
			word = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
			word[LEN_W-1:0] = LEN_W'(len);
			write_reg(REG_PATTERN_LENGTH, word);
			write_reg(REG_SECTION_BASE, base);
			write_reg(REG_PRIOR_ADDR, old);
			write_reg(REG_BASE_SHIFT, shift);

			eff = (len > 16) ? 16 : len;
			repeat ($urandom_range(2, 6)) begin
				nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 64)
					: $urandom_range(1, 30);
				// bytes drawn from the pattern make accidental hits likely
				mixed = $urandom_range(0, 1);
				section_bytes.delete();
				repeat (nbytes) begin
					pick = $urandom_range(0, 15);
					if (mixed && $urandom_range(0, 1))
						section_bytes = {section_bytes, pat[8*pick +: 8]};
					else
						section_bytes = {section_bytes, 8'($urandom)};
				end
				case ($urandom_range(0, 7))
					0:       plants = 0;
					1:       plants = $urandom_range(8, 14);
					default: plants = $urandom_range(1, 3);
				endcase
				if (eff > 0 && nbytes >= eff) begin
					repeat (plants) begin
						pos = $urandom_range(0, nbytes - eff);
						for (int j = 0; j < eff; j++)
							if (care[j])
								section_bytes[pos+j] = pat[8*j +: 8];
					end
				end
				feed_quiet = ($urandom_range(0, 4) == 0);
				send_section();
			end
			wait_idle();
		end

		if (pred.expected_reports.size() != 0)
			pred.errors++;
		if (pred.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
